>>> src/lmr_pkg.sv
// Shared types and constants for the length-prefixed message ring
package lmr_pkg;

    localparam int LEN_W     = 10;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 10;
    localparam int HDR_BYTES = 4;
    localparam logic [CNT_W-1:0] CNT_MAX = 10'd1023;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_PAYLOAD = 2'd1,
        REQ_RECV    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOSEND  = 2'd3
    } t_status;

    typedef struct packed {
        logic       load;
        logic       set_send;
        logic       wr_hdr;
        logic [1:0] hdr_idx;
        logic       wr_pay;
        logic       rd;
        logic       cap_lo;
        logic       cap_hi;
        logic       set_recv;
        logic       dec_recv;
        logic       emit;
        t_status    status;
        logic       with_data;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic send_zero;
        logic recv_zero;
        logic len_zero;
        logic space_ok;
        logic have_hdr;
        logic hdr_zero;
        logic out_free;
    } t_sts;

endpackage

>>> src/lmr_req_if.sv
// Request channel: valid/ready handshake carrying one request item
interface lmr_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  req_type;
    logic [lmr_pkg::LEN_W-1:0]   msg_len;
    logic [lmr_pkg::BYTE_W-1:0]  payload_byte;

    modport source (output valid, output req_type, output msg_len, output payload_byte,
                    input ready);
    modport sink   (input valid, input req_type, input msg_len, input payload_byte,
                    output ready);
endinterface

>>> src/lmr_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item
interface lmr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [lmr_pkg::BYTE_W-1:0]  data_out;
    logic                        last;
    logic [lmr_pkg::CNT_W-1:0]   used_bytes;
    logic [lmr_pkg::CNT_W-1:0]   free_bytes;

    modport source (output valid, output status, output data_out, output last,
                    output used_bytes, output free_bytes, input ready);
    modport sink   (input valid, input status, input data_out, input last,
                    input used_bytes, input free_bytes, output ready);
endinterface

>>> src/lmr_datapath.sv
// Datapath: byte store, ring pointers, message counters and result register
module lmr_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lmr_pkg::t_cmd               i_cmd,
    output lmr_pkg::t_sts               o_sts,
    input  logic [1:0]                  i_req_type,
    input  logic [lmr_pkg::LEN_W-1:0]   i_msg_len,
    input  logic [lmr_pkg::BYTE_W-1:0]  i_payload_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [lmr_pkg::BYTE_W-1:0]  o_data_out,
    output logic                        o_last,
    output logic [lmr_pkg::CNT_W-1:0]   o_used_bytes,
    output logic [lmr_pkg::CNT_W-1:0]   o_free_bytes
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > 11) ? CW : 11;
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [WW-1:0] DEPTH_W  = WW'(DEPTH);
    localparam logic [WW-1:0] HDR_W    = WW'(lmr_pkg::HDR_BYTES);
    localparam logic [WW-1:0] MAX_W    = WW'(lmr_pkg::CNT_MAX);

    logic [lmr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [lmr_pkg::BYTE_W-1:0] r_rd_data;

    logic [AW-1:0]                r_rd_ptr, r_wr_ptr, r_cm_ptr;
    logic [lmr_pkg::LEN_W-1:0]    r_send_rem, r_recv_rem;
    lmr_pkg::t_req                r_req;
    logic [lmr_pkg::LEN_W-1:0]    r_len;
    logic [lmr_pkg::BYTE_W-1:0]   r_pay;
    logic [lmr_pkg::BYTE_W-1:0]   r_b0;
    logic [1:0]                   r_b1;

    logic                         r_out_valid;
    logic [1:0]                   r_out_status;
    logic [lmr_pkg::BYTE_W-1:0]   r_out_data;
    logic                         r_out_last;
    logic [lmr_pkg::CNT_W-1:0]    r_out_used, r_out_free;

    logic [AW-1:0]                n_wr_ptr, n_rd_ptr;
    logic                         wr_en;
    logic [lmr_pkg::BYTE_W-1:0]   wr_data, hdr_byte;
    logic [WW-1:0]                rd_w, wr_w, cm_w, used_w, gap_w, free_w;
    logic [lmr_pkg::LEN_W-1:0]    hdr_len;

    assign n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        unique case (i_cmd.hdr_idx)
            2'd0:    hdr_byte = r_len[7:0];
            2'd1:    hdr_byte = {6'd0, r_len[9:8]};
            default: hdr_byte = '0;
        endcase
    end

    assign wr_en   = i_cmd.wr_hdr | i_cmd.wr_pay;
    assign wr_data = i_cmd.wr_hdr ? hdr_byte : r_pay;
    assign hdr_len = {r_b1, r_b0};

    assign rd_w   = WW'(r_rd_ptr);
    assign wr_w   = WW'(r_wr_ptr);
    assign cm_w   = WW'(r_cm_ptr);
    assign used_w = (cm_w >= rd_w) ? cm_w - rd_w : cm_w + DEPTH_W - rd_w;
    assign gap_w  = (rd_w > wr_w) ? rd_w - wr_w : rd_w + DEPTH_W - wr_w;
    assign free_w = (gap_w > HDR_W) ? gap_w - HDR_W : '0;

    always_comb begin
        o_sts.req       = r_req;
        o_sts.send_zero = (r_send_rem == '0);
        o_sts.recv_zero = (r_recv_rem == '0);
        o_sts.len_zero  = (r_len == '0);
        o_sts.space_ok  = (free_w >= WW'(r_len) + HDR_W);
        o_sts.have_hdr  = (used_w >= HDR_W);
        o_sts.hdr_zero  = (hdr_len == '0);
        o_sts.out_free  = ~r_out_valid | i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= lmr_pkg::t_req'(i_req_type);
            r_len <= i_msg_len;
            r_pay <= i_payload_byte;
        end
        if (i_cmd.cap_lo) begin
            r_b0 <= r_rd_data;
        end
        if (i_cmd.cap_hi) begin
            r_b1 <= r_rd_data[1:0];
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.status;
            r_out_data   <= i_cmd.with_data ? r_rd_data : '0;
            r_out_last   <= i_cmd.with_data & (r_recv_rem == '0);
            r_out_used   <= (used_w > MAX_W) ? lmr_pkg::CNT_MAX : used_w[lmr_pkg::CNT_W-1:0];
            r_out_free   <= (free_w > MAX_W) ? lmr_pkg::CNT_MAX : free_w[lmr_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_cm_ptr    <= '0;
            r_send_rem  <= '0;
            r_recv_rem  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_cmd.rd) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_cmd.set_send) begin
                r_send_rem <= r_len;
            end else if (i_cmd.wr_pay) begin
                r_send_rem <= r_send_rem - 1'b1;
                if (r_send_rem == lmr_pkg::LEN_W'(1)) begin
                    r_cm_ptr <= n_wr_ptr;
                end
            end
            if (i_cmd.set_recv) begin
                r_recv_rem <= hdr_len;
            end else if (i_cmd.dec_recv) begin
                r_recv_rem <= r_recv_rem - 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_data_out   = r_out_data;
    assign o_last       = r_out_last;
    assign o_used_bytes = r_out_used;
    assign o_free_bytes = r_out_free;

endmodule

>>> src/lmr_ctrl.sv
// Controller: sequences header writes, header reads and result delivery
module lmr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lmr_pkg::t_sts i_sts,
    output lmr_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HDR_WR,
        S_HDR_RD,
        S_HDR_CHK,
        S_PAY_RD,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_cnt, n_cnt;
    lmr_pkg::t_status  r_status, n_status;
    logic              r_with_data, n_with_data;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        o_cmd.status    = r_status;
        o_cmd.with_data = r_with_data;
        o_cmd.hdr_idx   = r_cnt;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_status    = r_status;
        n_with_data = r_with_data;
        unique case (r_state)
            S_IDLE: begin
                n_with_data = 1'b0;
                n_status    = lmr_pkg::ST_OK;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (i_sts.req)
                    lmr_pkg::REQ_START: begin
                        if (!i_sts.send_zero || i_sts.len_zero || !i_sts.space_ok) begin
                            n_status = lmr_pkg::ST_NOSPACE;
                        end else begin
                            o_cmd.set_send = 1'b1;
                            n_cnt          = 2'd0;
                            n_state        = S_HDR_WR;
                        end
                    end
                    lmr_pkg::REQ_PAYLOAD: begin
                        if (i_sts.send_zero) begin
                            n_status = lmr_pkg::ST_NOSEND;
                        end else begin
                            o_cmd.wr_pay = 1'b1;
                        end
                    end
                    lmr_pkg::REQ_RECV: begin
                        if (!i_sts.recv_zero) begin
                            o_cmd.rd       = 1'b1;
                            o_cmd.dec_recv = 1'b1;
                            n_with_data    = 1'b1;
                        end else if (!i_sts.have_hdr) begin
                            n_status = lmr_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd = 1'b1;
                            n_cnt    = 2'd1;
                            n_state  = S_HDR_RD;
                        end
                    end
                    default: begin
                        n_status = lmr_pkg::ST_OK;
                    end
                endcase
            end
            S_HDR_WR: begin
                o_cmd.wr_hdr = 1'b1;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == 2'd3) begin
                    n_state = S_DONE;
                end
            end
            S_HDR_RD: begin
                o_cmd.rd     = 1'b1;
                o_cmd.cap_lo = (r_cnt == 2'd1);
                o_cmd.cap_hi = (r_cnt == 2'd2);
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == 2'd3) begin
                    n_state = S_HDR_CHK;
                end
            end
            S_HDR_CHK: begin
                if (i_sts.hdr_zero) begin
                    n_status = lmr_pkg::ST_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.set_recv = 1'b1;
                    n_state        = S_PAY_RD;
                end
            end
            S_PAY_RD: begin
                o_cmd.rd       = 1'b1;
                o_cmd.dec_recv = 1'b1;
                n_with_data    = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_status    <= lmr_pkg::ST_OK;
            r_with_data <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_status    <= n_status;
            r_with_data <= n_with_data;
        end
    end

endmodule

>>> src/length_prefixed_message_ring_unit.sv
// Top level: length-prefixed message ring over a single-port-pair byte store
// Payloads, receives within a message, execute-time rejects and idle codes pass
// from execute straight to the result; an accepted send-start first does four
// header writes; a receive at a message boundary first does four header reads
// and one payload read. A new item waits until the previous result is emitted.
// Reset clears pointers, counters and the controller; byte store contents are kept.
module length_prefixed_message_ring_unit #(
    parameter int DEPTH = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmr_req_if.sink    i_req,
    lmr_rsp_if.source  o_rsp
);

    lmr_pkg::t_cmd cmd;
    lmr_pkg::t_sts sts;

    lmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lmr_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req.req_type),
        .i_msg_len      (i_req.msg_len),
        .i_payload_byte (i_req.payload_byte),
        .o_valid        (o_rsp.valid),
        .i_ready        (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_data_out     (o_rsp.data_out),
        .o_last         (o_rsp.last),
        .o_used_bytes   (o_rsp.used_bytes),
        .o_free_bytes   (o_rsp.free_bytes)
    );

endmodule
